[rtl/nps_pkg.sv]
package nps_pkg;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CAND   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic next_cand;
    logic div_start;
    logic div_step;
    logic next_div;
    logic publish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_two;
    logic is_even;
    logic root_done;
    logic div_last;
    logic rem_zero;
  } sts_t;

  localparam int SMALLEST_PRIME = 2;
  localparam int FIRST_DIVISOR  = 3;
  localparam int DIVISOR_STEP   = 2;

endpackage

[rtl/nps_if.sv]
interface nps_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_value;

  modport source (output valid, output start_value, input ready);
  modport sink (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] next_prime;

  modport source (output valid, output next_prime, input ready);
  modport sink (input valid, input next_prime, output ready);
endinterface

[rtl/nps_dp.sv]
module nps_dp #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic signed [31:0] start_value,
  input  nps_pkg::cmd_t      cmd,
  output nps_pkg::sts_t      sts,
  output logic [30:0]        next_prime
);

  localparam int DV = (DATA_WIDTH + 1) / 2 + 2;  // divisor width
  localparam int SW = 2 * DV;                    // divisor square width
  localparam int CW = $clog2(DATA_WIDTH);        // division step counter

  logic [DATA_WIDTH-1:0] raw;
  logic                  trivial;
  logic [DATA_WIDTH-1:0] cand;
  logic [DATA_WIDTH-1:0] shift;
  logic [DV-1:0]         div;
  logic [DV-1:0]         rem;
  logic [SW-1:0]         dsq;
  logic [CW-1:0]         cnt;
  logic [DV:0]           trial;
  logic [30:0]           result_q;

  assign raw     = start_value[DATA_WIDTH-1:0];
  assign trivial = raw[DATA_WIDTH-1] || (raw <= DATA_WIDTH'(nps_pkg::SMALLEST_PRIME));
  assign trial   = {rem, shift[DATA_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= trivial ? DATA_WIDTH'(nps_pkg::SMALLEST_PRIME) : raw;
    end else if (cmd.next_cand) begin
      cand <= cand + 1'b1;
    end

    // divisor and its square restart at three for every candidate
    if (cmd.load || cmd.next_cand) begin
      div <= DV'(nps_pkg::FIRST_DIVISOR);
      dsq <= SW'(nps_pkg::FIRST_DIVISOR * nps_pkg::FIRST_DIVISOR);
    end else if (cmd.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div <= div + DV'(nps_pkg::DIVISOR_STEP);
      dsq <= dsq + SW'({div, 2'b00}) + SW'(4);
    end

    // restoring remainder, one candidate bit per cycle
    if (cmd.div_start) begin
      rem   <= '0;
      shift <= cand;
      cnt   <= '0;
    end else if (cmd.div_step) begin
      rem   <= (trial >= {1'b0, div}) ? DV'(trial - {1'b0, div}) : trial[DV-1:0];
      shift <= shift << 1;
      cnt   <= cnt + 1'b1;
    end

    if (cmd.publish) begin
      result_q <= 31'(cand);
    end
  end

  assign sts.is_two    = (cand == DATA_WIDTH'(nps_pkg::SMALLEST_PRIME));
  assign sts.is_even   = !cand[0];
  assign sts.root_done = (dsq > SW'(cand));
  assign sts.div_last  = (cnt == CW'(DATA_WIDTH - 1));
  assign sts.rem_zero  = (rem == '0);
  assign next_prime    = result_q;

endmodule

[rtl/nps_ctrl.sv]
module nps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  nps_pkg::sts_t sts,
  output nps_pkg::cmd_t cmd
);

  nps_pkg::state_t state;
  nps_pkg::state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == nps_pkg::ST_IDLE);
    unique case (state)
      nps_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = nps_pkg::ST_CAND;
        end
      end
      nps_pkg::ST_CAND: begin
        if (sts.is_two || (!sts.is_even && sts.root_done)) begin
          state_next = nps_pkg::ST_FINISH;
        end else if (sts.is_even) begin
          cmd.next_cand = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = nps_pkg::ST_DIV;
        end
      end
      nps_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = nps_pkg::ST_CHECK;
        end
      end
      nps_pkg::ST_CHECK: begin
        // divisor hit: try next candidate, else next odd divisor
        if (sts.rem_zero) begin
          cmd.next_cand = 1'b1;
        end else begin
          cmd.next_div = 1'b1;
        end
        state_next = nps_pkg::ST_CAND;
      end
      nps_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nps_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/next_prime_search_unit.sv]
// next prime search: returns the smallest prime not less than a signed start value
//
// request channel carries start_value; only its low DATA_WIDTH bits are used, read as
// a two's complement number. any value of 2 or less, negatives included, gives 2.
// result channel carries next_prime. each item accepted on request gives one item
// on result, in order.
// one item is worked at a time; request.ready is high only while the search engine
// is idle. a finished result sits in an output register, so the next item is taken
// while the previous result still waits on a stalled receiver.
// each odd candidate tries odd divisors d from 3 while d*d <= candidate, each trial
// a radix-2 remainder over the DATA_WIDTH candidate bits; even candidates other than
// two go straight to the next candidate. the work grows with the number of trials
// and the number of candidates up to the next prime. the serial remainder unit sets
// the rate.
// reset (rst, synchronous) returns the controller to idle and empties the output
// register; no other state is kept between items.
module next_prime_search_unit #(
  parameter int DATA_WIDTH = 32
) (
  input logic      clk,
  input logic      rst,
  nps_in_if.sink   request,
  nps_out_if.source result
);

  nps_pkg::cmd_t cmd;
  nps_pkg::sts_t sts;

  // controller: sequences candidate checks, divisor trials and result hand-off
  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: candidate, divisor with running square, serial remainder, output register
  nps_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .start_value (request.start_value),
    .cmd         (cmd),
    .sts         (sts),
    .next_prime  (result.next_prime)
  );

`ifndef SYNTHESIS
  // every result is odd or exactly two
  a_result_prime_form: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.next_prime[0] || (result.next_prime == 31'd2)))
    else $error("result is even and not two");

  // one item at a time: no second accept right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request accepted while search busy");

  // a new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!result.valid || result.ready))
    else $error("output register overwritten");
`endif

endmodule

[tb/nps_prime_checker.sv]
`timescale 1ns / 100ps

module nps_prime_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  nps_in_if    request,
  nps_out_if   result,
  output int   fail_count,
  output int   outstanding,
  output int   primes_checked
);

  // primes still owed by the block, oldest first, with the start that asked for each
  logic [30:0]        owed_primes[$];
  logic signed [31:0] owed_starts[$];

  function automatic bit has_no_divisor(longint unsigned v);
    longint unsigned d;
    if (v < nps_pkg::SMALLEST_PRIME) return 1'b0;
    if (v == nps_pkg::SMALLEST_PRIME) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = nps_pkg::FIRST_DIVISOR; d * d <= v; d += nps_pkg::DIVISOR_STEP) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [30:0] smallest_prime_from(logic signed [31:0] start);
    longint unsigned width_mask;
    longint unsigned raw;
    longint unsigned cand;
    width_mask = (64'd1 << DATA_WIDTH) - 64'd1;
    raw = {32'd0, start} & width_mask;
    // negative at block width, or at most two
    if (raw[DATA_WIDTH-1] || raw <= nps_pkg::SMALLEST_PRIME)
      return 31'(nps_pkg::SMALLEST_PRIME);
    cand = raw;
    while (!has_no_divisor(cand)) cand++;
    return cand[30:0];
  endfunction

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    primes_checked = 0;
  end

  always @(posedge clk) begin : watch
    logic [30:0]        want;
    logic signed [31:0] origin;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (owed_primes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected next_prime item %0d", $realtime, result.next_prime);
        end else begin
          want   = owed_primes.pop_front();
          origin = owed_starts.pop_front();
          primes_checked++;
          if (result.next_prime !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: next_prime for start %0d: expected %0d, got %0d",
                       $realtime, origin, want, result.next_prime);
          end
        end
      end
      if (request.valid && request.ready) begin
        owed_primes.push_back(smallest_prime_from(request.start_value));
        owed_starts.push_back(request.start_value);
      end
      outstanding = owed_primes.size();
    end
  end

endmodule

[tb/next_prime_search_unit_test.sv]
`timescale 1ns / 100ps

module next_prime_search_unit_test;

  localparam int DATA_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 100;
  localparam int CALM_FROM    = 80;   // random items from here on run without idling
  // overall limit for the watchdog below
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int SETTLE       = 40;

  // directed starts: small values, negatives that all collapse to two, squares
  // of primes that sit exactly on the root bound, long prime gaps, a start just past
  // the top 16-bit prime, and both ends of the signed range
  localparam logic signed [31:0] CORNER_STARTS [22] = '{
    32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, -32'sd1, -32'sd2, 32'sh80000000,
    32'sd5, 32'sd8, 32'sd9, 32'sd24, 32'sd25, 32'sd49, 32'sd90, 32'sd114,
    32'sd121, 32'sd1369, 32'sd10201, 32'sd65522, 32'sd1000000, 32'sh7FFFFFFF
  };

  logic clk;
  logic rst;

  nps_in_if  request_ch ();
  nps_out_if result_ch ();

  int  fail_count;
  int  outstanding;
  int  primes_checked;
  bit  bursts_on = 1'b1;   // random idling on both sides
  int  stall_left = 0;
  int  sent_total = 0;
  int  sent_negative = 0;
  int  sent_wide = 0;

  next_prime_search_unit #(.DATA_WIDTH(DATA_WIDTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  nps_prime_checker #(.DATA_WIDTH(DATA_WIDTH)) prime_checker (
    .clk            (clk),
    .rst            (rst),
    .request        (request_ch),
    .result         (result_ch),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .primes_checked (primes_checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver: ready drops in random bursts while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      result_ch.ready = 1'b0;
      stall_left--;
    end else if (bursts_on && $urandom_range(0, 4) == 0) begin
      result_ch.ready = 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      result_ch.ready = 1'b1;
    end
  end

  // offer one start value, holding valid until the block takes it
  // valid stays high across back-to-back items unless idling inserts a gap, only the payload changes
  task automatic offer_start(input logic signed [31:0] value);
    int gap;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      request_ch.valid = 1'b0;
      request_ch.start_value = $urandom();   // junk while idle
      repeat (gap) @(negedge clk);
    end
    request_ch.valid = 1'b1;
    request_ch.start_value = value;
    do @(posedge clk); while (!request_ch.ready);
    sent_total++;
    if (value < 0) sent_negative++;
    if (value > 32'sd1048576) sent_wide++;
  endtask

  // most random starts stay small to keep each search short;
  // negatives carry random upper bits and cost nothing
  function automatic logic signed [31:0] pick_start();
    logic [31:0] bits;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      bits = $urandom();
      bits[31] = 1'b1;
      return bits;
    end
    if (sel < 25) return $urandom_range(0, 16);
    if (sel < 70) return $urandom_range(17, 4095);
    if (sel < 97) return $urandom_range(4096, 1 << 20);
    return $urandom_range(1 << 20, 1 << 24);
  endfunction

  // drain: stop offering and wait until the checker owes nothing
  task automatic drain_results();
    @(negedge clk);
    request_ch.valid = 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin
    rst = 1'b1;
    request_ch.valid = 1'b0;
    request_ch.start_value = '0;
    result_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    foreach (CORNER_STARTS[i]) offer_start(CORNER_STARTS[i]);

    // hold the sender until every owed prime has come back
    drain_results();

    // random part, idling switched off for the tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) bursts_on = 1'b0;
      if (i == RANDOM_ITEMS / 2) drain_results();
      offer_start(pick_start());
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d start values (%0d negative, %0d above 2^20, both signed extremes)",
             sent_total, sent_negative, sent_wide);
    $display("checked %0d next_prime items, %0d failures", primes_checked, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout with %0d next_prime items still owed", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
